[src/sps_pkg.sv]
// shared types and constants for the staggered power sequencer
// no dependencies; imported by every module of the block
package sps_pkg;

  localparam int unsigned BRICK_COUNT_DEF = 4;
  localparam int unsigned MASK_W          = 4;
  localparam int unsigned CFG_ADDR_W      = 2;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned S_TDATA_W       = 64;
  localparam int unsigned M_TDATA_W       = 8;

  localparam logic [15:0]        LOGIC_MIN_MV_RST    = 16'd5000;
  localparam logic [15:0]        LOGIC_STABLE_MS_RST = 16'd500;
  localparam logic [15:0]        STAGGER_MS_RST      = 16'd50;
  localparam logic signed [11:0] MAX_TEMP_RST        = 12'sd800;  // 50.0 degC

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_DIAG    = 3'd2,
    PH_STAGGER = 3'd3,
    PH_RUN     = 3'd4,
    PH_FAULT   = 3'd5
  } phase_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOGIC_MIN_MV    = 2'd0,
    CFG_LOGIC_STABLE_MS = 2'd1,
    CFG_STAGGER_MS      = 2'd2,
    CFG_MAX_TEMP        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        logic_min_mv;
    logic [15:0]        logic_stable_ms;
    logic [15:0]        stagger_ms;
    logic signed [11:0] max_temp;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [31:0]        now_ms;
    logic [15:0]        logic_mv;
    logic               diode_good;
    logic signed [11:0] board_temp;
  } item_t;

  typedef struct packed {
    phase_e             phase;
    logic [MASK_W-1:0]  brick_enables;
  } result_t;

endpackage

[src/sps_cfg_regs.sv]
// configuration register file of the power sequencer
// depends on sps_pkg
module sps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sps_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sps_pkg::cfg_t                  cfg_o
);
  import sps_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.logic_min_mv    <= LOGIC_MIN_MV_RST;
      cfg_q.logic_stable_ms <= LOGIC_STABLE_MS_RST;
      cfg_q.stagger_ms      <= STAGGER_MS_RST;
      cfg_q.max_temp        <= MAX_TEMP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_LOGIC_MIN_MV:    cfg_q.logic_min_mv    <= cfg_data_i;
        CFG_LOGIC_STABLE_MS: cfg_q.logic_stable_ms <= cfg_data_i;
        CFG_STAGGER_MS:      cfg_q.stagger_ms      <= cfg_data_i;
        CFG_MAX_TEMP:        cfg_q.max_temp        <= $signed(cfg_data_i[11:0]);
        default: ;
      endcase
    end
  end

endmodule

[src/sps_in_stage.sv]
// input holding register of the power sequencer
// depends on sps_pkg
module sps_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sps_pkg::item_t item_i,
  input  logic           step_i,
  output logic           valid_o,
  output sps_pkg::item_t item_o
);
  import sps_pkg::*;

  logic  valid_q;
  item_t item_q;

  // free slot, or the held item leaves this cycle
  assign in_ready_o = !valid_q || step_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[src/sps_core.sv]
// sequencing state and next-state logic of the power sequencer
// depends on sps_pkg
module sps_core #(
  parameter int unsigned BRICK_COUNT = sps_pkg::BRICK_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  sps_pkg::item_t   item_i,
  input  sps_pkg::cfg_t    cfg_i,
  output sps_pkg::result_t result_o
);
  import sps_pkg::*;

  localparam int unsigned IDX_W = $clog2(BRICK_COUNT + 1);

  phase_e            phase_q, phase_d;
  logic [31:0]       start_q, start_d;
  logic [IDX_W-1:0]  idx_q, idx_d, idx_inc;
  logic [MASK_W-1:0] mask_q, mask_d, bit_sel;
  logic [31:0]       elapsed;
  logic              checks_bad;

  assign elapsed    = item_i.now_ms - start_q;
  assign idx_inc    = idx_q + 1'b1;
  assign checks_bad = !item_i.diode_good || (item_i.board_temp >= cfg_i.max_temp);

  always_comb begin
    for (int b = 0; b < MASK_W; b++) begin
      bit_sel[b] = (int'(idx_q) == b);
    end
  end

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    idx_d   = idx_q;
    mask_d  = mask_q;
    if (item_i.func) begin
      mask_d  = '0;
      phase_d = PH_FAULT;
    end else begin
      case (phase_q)
        PH_INIT: begin
          mask_d  = '0;
          phase_d = PH_WAIT;
          start_d = item_i.now_ms;
        end
        PH_WAIT: begin
          if (item_i.logic_mv > cfg_i.logic_min_mv) begin
            if (elapsed >= 32'(cfg_i.logic_stable_ms)) phase_d = PH_DIAG;
          end else begin
            start_d = item_i.now_ms;
          end
        end
        PH_DIAG: begin
          if (checks_bad) begin
            mask_d  = '0;
            phase_d = PH_FAULT;
          end else begin
            idx_d   = '0;
            start_d = item_i.now_ms;
            phase_d = PH_STAGGER;
          end
        end
        PH_STAGGER: begin
          if (elapsed >= 32'(cfg_i.stagger_ms)) begin
            mask_d  = mask_q | bit_sel;   // bricks past the mask stay invisible
            idx_d   = idx_inc;
            start_d = item_i.now_ms;
            if (int'(idx_inc) >= int'(BRICK_COUNT)) phase_d = PH_RUN;
          end
        end
        PH_RUN: begin
          if (checks_bad) begin
            mask_d  = '0;
            phase_d = PH_FAULT;
          end
        end
        PH_FAULT: begin
          mask_d = '0;
        end
        default: begin
          mask_d  = '0;
          phase_d = PH_FAULT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INIT;
      start_q <= '0;
      idx_q   <= '0;
      mask_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
      idx_q   <= idx_d;
      mask_q  <= mask_d;
    end
  end

  assign result_o.phase         = phase_d;
  assign result_o.brick_enables = mask_d;

endmodule

[src/sps_out_stage.sv]
// result register of the power sequencer
// depends on sps_pkg
module sps_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sps_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sps_pkg::result_t result_o
);
  import sps_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

[src/staggered_power_sequencer.sv]
// top level of the staggered power sequencer
// depends on sps_pkg, sps_cfg_regs, sps_in_stage, sps_core, sps_out_stage
//
// Power-on sequencer for a set of power bricks. Every input transfer is one
// step: it carries the millisecond time, the logic rail voltage, the ideal
// diode status, the board temperature and, in tuser, the op (0 step,
// 1 emergency stop). Every input transfer yields exactly one output transfer
// that shows the phase and the brick enables after that step. After reset
// the first step leaves init for wait-logic; the rail must stay strictly
// above logic_min_mv for logic_stable_ms (the timer restarts whenever the
// rail drops), then one diagnostics step checks the diode and temperature,
// then the bricks come on one per stagger_ms and the block monitors while
// running. An emergency stop at any step, or a bad diode or a temperature at
// or above max_temp in the diagnostics step or while running, latches the
// fault phase with all bricks off until reset. Time differences wrap modulo
// 2^32. Rate: one item per clock cycle sustained while the result stream
// is not stalled; each result passes the input register, then the state
// update and result register. The sequencing state sits in a single register
// bank updated once per step, so that bank sets the rate.
// Configuration writes are taken at any time but are meant for idle periods.
module staggered_power_sequencer #(
  parameter int unsigned BRICK_COUNT = sps_pkg::BRICK_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] now_ms, [47:32] logic_mv, [48] diode_good, [60:49] board_temp, rest zero
  input  logic [sps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic                           s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] phase, [6:3] brick_enables, [7] zero
  output logic [sps_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sps_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sps_pkg::*;

  cfg_t    cfg;
  item_t   in_item, held_item;
  result_t next_result, out_result;
  logic    held_valid;
  logic    out_free;
  logic    step;

  // unpack the input transfer
  assign in_item.func       = s_axis_tuser;
  assign in_item.now_ms     = s_axis_tdata[31:0];
  assign in_item.logic_mv   = s_axis_tdata[47:32];
  assign in_item.diode_good = s_axis_tdata[48];
  assign in_item.board_temp = $signed(s_axis_tdata[60:49]);

  // a held item advances whenever the result register can take its result
  assign step = held_valid && out_free;

  sps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sps_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (in_item),
    .step_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  sps_core #(
    .BRICK_COUNT (BRICK_COUNT)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (held_item),
    .cfg_i    (cfg),
    .result_o (next_result)
  );

  sps_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (next_result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  // pack the result transfer
  assign m_axis_tdata = {1'b0, out_result.brick_enables, out_result.phase};

endmodule

[src/sps_checker.sv]
// port-level checks for the staggered power sequencer, bound to the top level
// depends on sps_pkg and staggered_power_sequencer
module sps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import sps_pkg::*;

  logic [2:0] out_phase;
  logic [3:0] out_mask;
  logic       fault_seen_q;

  assign out_phase = m_axis_tdata[2:0];
  assign out_mask  = m_axis_tdata[6:3];

  // remembers that a fault result was already delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && (out_phase == PH_FAULT)) begin
      fault_seen_q <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // fault is latched until reset
  a_fault_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && fault_seen_q |-> out_phase == PH_FAULT)
    else $error("left fault phase without reset");

  // bricks are on only while staggering or running
  a_mask_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_mask != 4'd0) |->
      (out_phase == PH_STAGGER) || (out_phase == PH_RUN))
    else $error("brick enabled outside stagger or run");

  // every step leaves init behind
  a_no_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_phase != PH_INIT)
    else $error("result shows init phase");

endmodule

bind staggered_power_sequencer sps_checker u_sps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[dv/staggered_power_sequencer_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for the staggered power sequencer
// depends on sps_pkg and the staggered_power_sequencer rtl only
module staggered_power_sequencer_test;
  import sps_pkg::*;

  localparam int unsigned BRICKS     = BRICK_COUNT_DEF;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned REPORT_CAP = 100;

  // one directed step; pinned rows carry a hand-written expected status
  typedef struct {
    item_t   step;
    bit      pinned;
    result_t status;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor copy of the registers
  logic [15:0]        rail_min_mv;
  logic [15:0]        rail_settle_ms;
  logic [15:0]        brick_gap_ms;
  logic signed [11:0] temp_limit;

  // predictor copy of the sequencing state
  phase_e      seq_ph;
  logic [31:0] phase_t0;
  int unsigned next_brick;
  logic [3:0]  brick_mask;

  // phase/enable status words still owed by the block, oldest first
  result_t     pending_status [$];

  // stimulus knobs, changed between segments
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned step_max;
  int unsigned jump_odds;
  logic [31:0] now_cursor;

  int unsigned status_errors = 0;
  int unsigned reported = 0;
  int unsigned cycle_count = 0;
  int unsigned cause;
  item_t       trigger;

  // rail and timer special cases, all while waiting for the logic rail:
  // at the minimum restarts the timer, one above counts, wrap across 2^32,
  // a backwards time reads as a huge elapsed time but the rail is at min
  dir_row_t dir_rows [10] = '{
    '{'{1'b0, 32'hFFFF_FE00, 16'd0,     1'b0, 12'h800}, 1'b1, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'hFFFF_FE10, 16'd5000,  1'b1, 12'h7FF}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'hFFFF_FF00, 16'd5001,  1'b0, 12'h000}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'h0000_0003, 16'hFFFF,  1'b1, 12'hFFF}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'h0000_0003, 16'd0,     1'b0, 12'd799}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'h0000_01F6, 16'd5001,  1'b1, 12'd800}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'hFFFF_FFFF, 16'd5000,  1'b1, 12'h800}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'h0000_0000, 16'd5001,  1'b0, 12'h7FF}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'h0000_01F2, 16'd5001,  1'b1, 12'h555}, 1'b0, '{PH_WAIT, 4'h0}},
    '{'{1'b0, 32'h0000_01F2, 16'd4999,  1'b0, 12'hAAA}, 1'b0, '{PH_WAIT, 4'h0}}
  };

  staggered_power_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one step of the sequencer; returns the status after the step
  function automatic result_t predict_status(input item_t it);
    result_t     res;
    logic [31:0] elapsed;
    elapsed = it.now_ms - phase_t0;
    if (it.func) begin
      // emergency stop wins in every phase, other fields ignored
      brick_mask = '0;
      seq_ph     = PH_FAULT;
    end else begin
      case (seq_ph)
        PH_INIT: begin
          brick_mask = '0;
          seq_ph     = PH_WAIT;
          phase_t0   = it.now_ms;
        end
        PH_WAIT: begin
          if (it.logic_mv > rail_min_mv) begin
            if (elapsed >= {16'h0, rail_settle_ms}) seq_ph = PH_DIAG;
          end else begin
            // rail not above minimum: restart the settle timer
            phase_t0 = it.now_ms;
          end
        end
        PH_DIAG: begin
          if (!it.diode_good || it.board_temp >= temp_limit) begin
            brick_mask = '0;
            seq_ph     = PH_FAULT;
          end else begin
            next_brick = 0;
            phase_t0   = it.now_ms;
            seq_ph     = PH_STAGGER;
          end
        end
        PH_STAGGER: begin
          if (elapsed >= {16'h0, brick_gap_ms}) begin
            // bricks past the mask width have no visible enable
            if (next_brick < MASK_W) brick_mask[next_brick] = 1'b1;
            next_brick++;
            phase_t0 = it.now_ms;
            if (next_brick >= BRICKS) seq_ph = PH_RUN;
          end
        end
        PH_RUN: begin
          if (!it.diode_good || it.board_temp >= temp_limit) begin
            brick_mask = '0;
            seq_ph     = PH_FAULT;
          end
        end
        PH_FAULT: brick_mask = '0;
        default: begin
          brick_mask = '0;
          seq_ph     = PH_FAULT;
        end
      endcase
    end
    res.phase         = seq_ph;
    res.brick_enables = brick_mask;
    return res;
  endfunction

  // random step shaped by the predicted phase; unless fault_ok, the
  // checked phases see a good diode and a temperature under the limit
  function automatic item_t next_item(input bit fault_ok);
    item_t       it;
    int unsigned roll;
    int unsigned hi;
    if ($urandom_range(1, jump_odds) == 1) now_cursor = $urandom;
    else now_cursor = now_cursor + $urandom_range(0, step_max);
    it.now_ms = now_cursor;
    it.func   = fault_ok && ($urandom_range(0, 19) == 0);
    roll      = $urandom_range(0, 99);
    if (seq_ph == PH_WAIT && roll < 65 && rail_min_mv != 16'hFFFF)
      it.logic_mv = 16'($urandom_range(int'(rail_min_mv) + 1, 65535));
    else if (seq_ph == PH_WAIT && roll < 80)
      it.logic_mv = rail_min_mv;
    else
      it.logic_mv = 16'($urandom);
    if (!fault_ok && (seq_ph == PH_DIAG || seq_ph == PH_RUN)) begin
      it.diode_good = 1'b1;
      hi = int'(temp_limit) + 2047;
      if ($urandom_range(0, 3) == 0) it.board_temp = temp_limit - 12'sd1;
      else it.board_temp = 12'($urandom_range(0, hi) + 32'h800);  // offset from -2048
    end else begin
      it.diode_good = 1'($urandom);
      it.board_temp = 12'($urandom);
    end
    return it;
  endfunction

  // temperature limit that still leaves room below it
  function automatic logic [15:0] mild_limit();
    int lim;
    lim = int'($urandom_range(0, 4047)) - 2000;
    return {4'($urandom), 12'(lim)};
  endfunction

  // one input transfer; the caller ends a burst by lowering tvalid
  task automatic push_step(input item_t it, input bit pinned, input result_t pin);
    result_t res;
    res = predict_status(it);
    pending_status.push_back(pinned ? pin : res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {3'b0, it.board_temp, it.diode_good, it.logic_mv, it.now_ms};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LOGIC_MIN_MV:    rail_min_mv    = val;
      CFG_LOGIC_STABLE_MS: rail_settle_ms = val;
      CFG_STAGGER_MS:      brick_gap_ms   = val;
      CFG_MAX_TEMP:        temp_limit     = val[11:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // hold off until every owed status has come back, plus pipeline slack
  task automatic drain();
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_segment(input int unsigned n, input int unsigned tx,
                             input int unsigned rx, input int unsigned stp,
                             input int unsigned odds);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    step_max    = stp;
    jump_odds   = odds;
    repeat (n) push_step(next_item(1'b0), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver side: random stalls per cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // compare every output transfer with the oldest owed status
  always @(posedge clk_i) begin
    result_t due;
    phase_e  got_ph;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_ph = phase_e'(m_axis_tdata[2:0]);
      if (pending_status.size() == 0) begin
        status_errors++;
        if (reported < REPORT_CAP)
          $display("%0t: unexpected transfer, expected none, actual phase %0d mask %h",
                   $time, got_ph, m_axis_tdata[6:3]);
        reported++;
      end else begin
        due = pending_status.pop_front();
        if (got_ph !== due.phase || m_axis_tdata[6:3] !== due.brick_enables) begin
          status_errors++;
          if (reported < REPORT_CAP)
            $display("%0t: expected phase %0d mask %h, actual phase %0d mask %h",
                     $time, due.phase, due.brick_enables, got_ph, m_axis_tdata[6:3]);
          reported++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_addr_i     = CFG_LOGIC_MIN_MV;
    cfg_data_i     = '0;
    tx_idle_pct    = 16;
    rx_idle_pct    = 56;
    step_max       = 300;
    jump_odds      = 200;
    rail_min_mv    = LOGIC_MIN_MV_RST;
    rail_settle_ms = LOGIC_STABLE_MS_RST;
    brick_gap_ms   = STAGGER_MS_RST;
    temp_limit     = MAX_TEMP_RST;
    seq_ph         = PH_INIT;
    phase_t0       = '0;
    next_brick     = 0;
    brick_mask     = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed steps against reset register values
    foreach (dir_rows[i]) push_step(dir_rows[i].step, dir_rows[i].pinned, dir_rows[i].status);
    s_axis_tvalid <= 1'b0;
    now_cursor = dir_rows[9].step.now_ms;
    drain();

    // longest settle time: mostly rail noise while waiting for the rail
    write_reg(CFG_LOGIC_MIN_MV, 16'($urandom_range(1000, 60000)));
    write_reg(CFG_LOGIC_STABLE_MS, 16'hFFFF);
    write_reg(CFG_STAGGER_MS, 16'($urandom));
    write_reg(CFG_MAX_TEMP, mild_limit());
    run_segment(280, 16, 56, 300, 200);
    drain();

    // rail minimum zero, longest stagger, highest temperature limit;
    // upper data bits of the limit are don't-care
    write_reg(CFG_LOGIC_MIN_MV, 16'h0000);
    write_reg(CFG_LOGIC_STABLE_MS, 16'($urandom_range(0, 2000)));
    write_reg(CFG_STAGGER_MS, 16'hFFFF);
    write_reg(CFG_MAX_TEMP, {4'($urandom), 12'h7FF});
    run_segment(250, 56, 16, 300, 40);
    drain();

    // zero stagger finishes any staggering, then run; a rail minimum of 16'hFFFF holds a waiting sequencer in wait
    write_reg(CFG_LOGIC_MIN_MV, 16'hFFFF);
    write_reg(CFG_LOGIC_STABLE_MS, 16'h0000);
    write_reg(CFG_STAGGER_MS, 16'h0000);
    write_reg(CFG_MAX_TEMP, mild_limit());
    run_segment(250, 0, 0, 65535, 50);
    drain();

    // closing stretch: fault latches until reset, so it comes last;
    // lowest limit means any checked temperature is at or above it
    write_reg(CFG_MAX_TEMP, {4'($urandom), 12'h800});
    cause   = $urandom_range(0, 2);
    trigger = next_item(1'b1);
    trigger.func = (cause == 0);
    if (cause == 1) trigger.diode_good = 1'b0;
    if (cause == 2) begin
      trigger.diode_good = 1'b1;
      trigger.board_temp = temp_limit;
    end
    push_step(trigger, 1'b0, '0);
    repeat (40) push_step(next_item(1'b1), 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    if (status_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
